>>> rtl/core/ssid_pkg.sv
`default_nettype none

package ssid_pkg;

   localparam int VALUE_W        = 32;
   localparam int COUNT_OUT_W    = 5;
   localparam int CAPACITY_DEF   = 16;
   localparam int DATA_WIDTH_DEF = 32;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   // Shift commands broadcast to every cell in the row
   typedef struct packed {
      logic ins_en;
      logic del_en;
   } cell_ctrl_type;

endpackage : ssid_pkg

`default_nettype wire

>>> rtl/core/ssid_cell.sv
`default_nettype none

module ssid_cell #(
   parameter int DATA_WIDTH = ssid_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire ssid_pkg::cell_ctrl_type ctrl,
   input  wire logic [DATA_WIDTH-1:0]   key,
   input  wire logic                    occupied,
   input  wire logic                    left_lt,
   input  wire logic [DATA_WIDTH-1:0]   left_entry,
   input  wire logic [DATA_WIDTH-1:0]   right_entry,
   output      logic [DATA_WIDTH-1:0]   entry,
   output      logic                    lt,
   output      logic                    eq
);
   import ssid_pkg::*;

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;

   assign lt    = occupied && ($signed(entry_ff) < $signed(key));
   assign eq    = occupied && (entry_ff == key);
   assign entry = entry_ff;

   // Cells at or above the sorted position move; those below hold
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en && !lt) begin
         entry_in = left_lt ? key : left_entry;
      end else if (ctrl.del_en && !lt) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule : ssid_cell

`default_nettype wire

>>> rtl/core/sorted_set_insert_delete.sv
`default_nettype none

// Sorted set of up to CAPACITY distinct signed values, kept in ascending order
// in a row of cells. Each item is an insert or a delete of one value and gives
// one result: ok, was_present, full_res and the count held afterwards. Every
// cell compares its entry with the item's value in the same cycle and the row
// shifts by one place, so an item is accepted on every cycle (its result is
// registered) unless a finished result is still held by rsp_stall. The
// throughput is set by the combinational compare across all cells followed
// by the shift of the row.
module sorted_set_insert_delete #(
   parameter int CAPACITY   = ssid_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = ssid_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic                               req_operation,
   input  wire logic signed [ssid_pkg::VALUE_W-1:0] req_value,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic                               rsp_ok,
   output      logic                               rsp_was_present,
   output      logic                               rsp_full_res,
   output      logic [ssid_pkg::COUNT_OUT_W-1:0]   rsp_entry_count
);
   import ssid_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [DATA_WIDTH-1:0] key;
   logic [DATA_WIDTH-1:0] entry_vec [CAPACITY];
   logic [CAPACITY-1:0]   lt_vec;
   logic [CAPACITY-1:0]   eq_vec;
   logic [CAPACITY-1:0]   occ_vec;
   cell_ctrl_type         ctrl;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   ok_ff, ok_in;
   logic                   present_ff;
   logic                   full_ff, full_in;
   logic [COUNT_OUT_W-1:0] cnt_out_ff;

   logic accept;
   logic present;
   logic full;
   logic is_insert;

   generate
      if (DATA_WIDTH <= VALUE_W) begin : g_key_trunc
         assign key = req_value[DATA_WIDTH-1:0];
      end else begin : g_key_ext
         assign key = {{(DATA_WIDTH - VALUE_W){req_value[VALUE_W-1]}}, req_value};
      end
   endgenerate

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_insert = (op_type'(req_operation) == OP_INSERT);
   assign present   = |eq_vec;
   assign full      = (count_ff == CNT_W'(CAPACITY));

   assign ctrl.ins_en = accept && is_insert && !present && !full;
   assign ctrl.del_en = accept && !is_insert && present;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic                  left_lt;
         logic [DATA_WIDTH-1:0] left_entry;
         logic [DATA_WIDTH-1:0] right_entry;

         assign occ_vec[gi] = (CNT_W'(gi) < count_ff);

         if (gi == 0) begin : g_first
            assign left_lt    = 1'b1;
            assign left_entry = key;
         end else begin : g_mid
            assign left_lt    = lt_vec[gi-1];
            assign left_entry = entry_vec[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_last
            assign right_entry = entry_vec[gi];
         end else begin : g_inner
            assign right_entry = entry_vec[gi+1];
         end

         ssid_cell #(
            .DATA_WIDTH (DATA_WIDTH)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .key         (key),
            .occupied    (occ_vec[gi]),
            .left_lt     (left_lt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entry_vec[gi]),
            .lt          (lt_vec[gi]),
            .eq          (eq_vec[gi])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.del_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign ok_in        = ctrl.ins_en || ctrl.del_en;
   assign full_in      = is_insert && !present && full;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result register only on accept; hold it while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff      <= ok_in;
         present_ff <= present;
         full_ff    <= full_in;
         cnt_out_ff <= COUNT_OUT_W'(count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_was_present = present_ff;
   assign rsp_full_res    = full_ff;
   assign rsp_entry_count = cnt_out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count beyond capacity");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.ins_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not advance count");

   a_ok_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(ok_ff && full_ff))
      else $error("ok and full both set");

   a_eq_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(eq_vec))
      else $error("duplicate value in set");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      (lt_vec[CAPACITY-1:1] & ~lt_vec[CAPACITY-2:0]) == '0)
      else $error("entries out of order");

endmodule : sorted_set_insert_delete

`default_nettype wire
